// ===== src/gpp_pkg.sv =====
// ----------------------------------------------------------------------------
// gpp_pkg
// Widths, register indexes and reset values shared by the gradient pattern
// pixel packer and its channel interfaces.
// ----------------------------------------------------------------------------
package gpp_pkg;

    localparam int COL_W      = 12;  // pixel_column
    localparam int ROW_W      = 12;  // pixel_row
    localparam int DIM_W      = 13;  // frame_width, frame_height
    localparam int BITS_W     = 4;   // channel bit widths
    localparam int POS_W      = 5;   // channel positions
    localparam int CHAN_W     = 8;   // one color channel before rescaling
    localparam int WORD_W     = 32;  // packed pixel word
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Coordinate times 255, and the rescale product v*(2^n-1)+127.
    localparam int PROD_W     = COL_W + CHAN_W;
    localparam int MUL_W      = 15;
    localparam int TOP_W      = 7;
    // One quotient bit per divider stage; the ramp quotient stays below 255.
    localparam int QUO_STEPS  = CHAN_W;
    localparam int DIV_CMP_W  = ((PROD_W > DIM_W + QUO_STEPS - 1) ?
                                 PROD_W : DIM_W + QUO_STEPS - 1) + 1;

    localparam int MAX_DIM_DEFAULT = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BITS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_POSITION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BITS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_POSITION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BITS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_POSITION  = 3'd7;

    // Reset values.
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT   = 13'd480;
    localparam logic [BITS_W-1:0] RST_RED_BITS       = 4'd8;
    localparam logic [POS_W-1:0]  RST_RED_POSITION   = 5'd16;
    localparam logic [BITS_W-1:0] RST_GREEN_BITS     = 4'd8;
    localparam logic [POS_W-1:0]  RST_GREEN_POSITION = 5'd8;
    localparam logic [BITS_W-1:0] RST_BLUE_BITS      = 4'd8;
    localparam logic [POS_W-1:0]  RST_BLUE_POSITION  = 5'd0;

    // Payload of the prep stage and of every divider stage.
    typedef struct packed {
        logic [PROD_W-1:0] rem_red;
        logic [PROD_W-1:0] rem_green;
        logic [CHAN_W-1:0] quo_red;
        logic [CHAN_W-1:0] quo_green;
        logic [CHAN_W-1:0] blue;
        logic              outside;
    } div_stage_t;

    // Payload of the rescale multiply stage.
    typedef struct packed {
        logic [MUL_W-1:0]  prod_red;
        logic [MUL_W-1:0]  prod_green;
        logic [MUL_W-1:0]  prod_blue;
        logic [CHAN_W-1:0] raw_red;
        logic [CHAN_W-1:0] raw_green;
        logic [CHAN_W-1:0] raw_blue;
        logic              outside;
    } mul_stage_t;

endpackage

// ===== src/gpp_coord_if.sv =====
// ----------------------------------------------------------------------------
// gpp_coord_if
// Valid/ready channel that carries one pixel coordinate per word.
// ----------------------------------------------------------------------------
interface gpp_coord_if
    import gpp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pixel_column;
    logic [ROW_W-1:0] pixel_row;

    modport source (output valid, output pixel_column, output pixel_row, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

// ===== src/gpp_pixel_if.sv =====
// ----------------------------------------------------------------------------
// gpp_pixel_if
// Valid/ready channel that carries one packed pixel word per word.
// ----------------------------------------------------------------------------
interface gpp_pixel_if
    import gpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_word;
    logic              outside_frame;

    modport source (output valid, output pixel_word, output outside_frame, input ready);
    modport sink   (input valid, input pixel_word, input outside_frame, output ready);
endinterface

// ===== src/gradient_pattern_pixel_packer.sv =====
// ----------------------------------------------------------------------------
// gradient_pattern_pixel_packer
// Test pattern generator: red and green ramps over the frame, blue from the
// coordinate xor, each rescaled to its field width and packed into one word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                       Handshake
//  coord     in         pixel_column, pixel_row       valid/ready
//  pixel     out        pixel_word, outside_frame     valid/ready
//  cfg       in         cfg_index, cfg_data           cfg_wr_en, no back-pressure
//
//  One coordinate word is accepted per cycle while coord.ready is high.
//  The pipeline holds the two restoring dividers, one quotient bit
//  per stage over eight stages, plus a prep, a multiply and a pack stage.
//  Every stage holds its word while the next one is full and stalled, so
//  bubbles are squeezed out and coord.ready only drops when all stages are full.
//  Reset clears the stage valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module gradient_pattern_pixel_packer
    import gpp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    gpp_coord_if.sink             coord,
    gpp_pixel_if.source           pixel,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DIM_CAP = (MAX_DIM > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(DIM_CAP);
    localparam int MUL_IDX = QUO_STEPS + 1;
    localparam int OUT_IDX = QUO_STEPS + 2;
    localparam int NUM_ST  = QUO_STEPS + 3;

    // Exact t/255 for t below 65281.
    function automatic logic [CHAN_W-1:0] div255(input logic [MUL_W-1:0] t);
        logic [MUL_W+1:0] s;
        s = (MUL_W+2)'(t) + (MUL_W+2)'(t >> 8) + (MUL_W+2)'(1);
        return CHAN_W'(s >> 8);
    endfunction

    function automatic logic [CHAN_W-1:0] chan_sel(input logic [MUL_W-1:0]  prod,
                                                   input logic [CHAN_W-1:0] raw,
                                                   input logic [BITS_W-1:0] n);
        logic [CHAN_W-1:0] v;
        if (n == '0)
            v = '0;
        else if (n >= BITS_W'(CHAN_W))
            v = raw;
        else
            v = div255(prod);
        return v;
    endfunction

    function automatic logic [TOP_W-1:0] top_val(input logic [BITS_W-1:0] n);
        logic [CHAN_W-1:0] t;
        t = (CHAN_W'(1) << n[2:0]) - CHAN_W'(1);
        return TOP_W'(t);
    endfunction

    function automatic logic [WORD_W-1:0] place(input logic [CHAN_W-1:0] v,
                                                input logic [POS_W-1:0]  pos);
        logic [WORD_W-1:0] w;
        w = WORD_W'(v) << pos;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  frame_width_reg,    frame_height_reg;
    logic [BITS_W-1:0] red_bits_reg,       green_bits_reg,     blue_bits_reg;
    logic [POS_W-1:0]  red_position_reg,   green_position_reg, blue_position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            red_bits_reg       <= RST_RED_BITS;
            red_position_reg   <= RST_RED_POSITION;
            green_bits_reg     <= RST_GREEN_BITS;
            green_position_reg <= RST_GREEN_POSITION;
            blue_bits_reg      <= RST_BLUE_BITS;
            blue_position_reg  <= RST_BLUE_POSITION;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                REG_RED_BITS:       red_bits_reg       <= cfg_data[BITS_W-1:0];
                REG_RED_POSITION:   red_position_reg   <= cfg_data[POS_W-1:0];
                REG_GREEN_BITS:     green_bits_reg     <= cfg_data[BITS_W-1:0];
                REG_GREEN_POSITION: green_position_reg <= cfg_data[POS_W-1:0];
                REG_BLUE_BITS:      blue_bits_reg      <= cfg_data[BITS_W-1:0];
                REG_BLUE_POSITION:  blue_position_reg  <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_lim, h_lim;

    assign w_lim = (frame_width_reg  > DIM_LIMIT) ? DIM_LIMIT : frame_width_reg;
    assign h_lim = (frame_height_reg > DIM_LIMIT) ? DIM_LIMIT : frame_height_reg;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its word moves on.
    // ------------------------------------------------------------------
    logic [NUM_ST-1:0] vld_reg, vld_next;
    logic [NUM_ST:0]   rdy;
    logic [NUM_ST-1:0] up_vld;

    always_comb
    begin
        rdy[NUM_ST] = pixel.ready;
        for (int k = NUM_ST - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
        up_vld = {vld_reg[NUM_ST-2:0], coord.valid};
        for (int k = 0; k < NUM_ST; k++)
            vld_next[k] = rdy[k] ? up_vld[k] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign coord.ready = rdy[0];

    // ------------------------------------------------------------------
    // Prep stage: ramp dividends, blue value and the outside flag.
    // ------------------------------------------------------------------
    div_stage_t div_reg [QUO_STEPS+1];
    div_stage_t prep_next;

    always_comb
    begin
        prep_next.rem_red   = (PROD_W'(coord.pixel_column) << CHAN_W)
                            - PROD_W'(coord.pixel_column);
        prep_next.rem_green = (PROD_W'(coord.pixel_row) << CHAN_W)
                            - PROD_W'(coord.pixel_row);
        prep_next.quo_red   = '0;
        prep_next.quo_green = '0;
        prep_next.blue      = CHAN_W'(coord.pixel_column ^ coord.pixel_row);
        prep_next.outside   = (DIM_W'(coord.pixel_column) >= w_lim)
                           || (DIM_W'(coord.pixel_row)    >= h_lim);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            div_reg[0] <= prep_next;
    end

    // ------------------------------------------------------------------
    // Divider stages: stage k settles quotient bit QUO_STEPS-k of both ramps.
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= QUO_STEPS; k++)
    begin : g_div
        localparam int SH = QUO_STEPS - k;
        logic [DIV_CMP_W-1:0] dsr_red, dsr_green, rem_red_x, rem_green_x;
        logic                 take_red, take_green;
        div_stage_t           div_next;

        always_comb
        begin
            dsr_red     = DIV_CMP_W'(w_lim) << SH;
            dsr_green   = DIV_CMP_W'(h_lim) << SH;
            rem_red_x   = DIV_CMP_W'(div_reg[k-1].rem_red);
            rem_green_x = DIV_CMP_W'(div_reg[k-1].rem_green);
            take_red    = rem_red_x   >= dsr_red;
            take_green  = rem_green_x >= dsr_green;
            div_next    = div_reg[k-1];
            if (take_red)
                div_next.rem_red = PROD_W'(rem_red_x - dsr_red);
            if (take_green)
                div_next.rem_green = PROD_W'(rem_green_x - dsr_green);
            div_next.quo_red   = {div_reg[k-1].quo_red[CHAN_W-2:0],   take_red};
            div_next.quo_green = {div_reg[k-1].quo_green[CHAN_W-2:0], take_green};
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
                div_reg[k] <= div_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: v*(2^n-1)+127 for each channel.
    // ------------------------------------------------------------------
    mul_stage_t mul_reg, mul_next;

    always_comb
    begin
        mul_next.raw_red    = div_reg[QUO_STEPS].quo_red;
        mul_next.raw_green  = div_reg[QUO_STEPS].quo_green;
        mul_next.raw_blue   = div_reg[QUO_STEPS].blue;
        mul_next.prod_red   = MUL_W'(mul_next.raw_red)   * MUL_W'(top_val(red_bits_reg))
                            + MUL_W'(127);
        mul_next.prod_green = MUL_W'(mul_next.raw_green) * MUL_W'(top_val(green_bits_reg))
                            + MUL_W'(127);
        mul_next.prod_blue  = MUL_W'(mul_next.raw_blue)  * MUL_W'(top_val(blue_bits_reg))
                            + MUL_W'(127);
        mul_next.outside    = div_reg[QUO_STEPS].outside;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[MUL_IDX])
            mul_reg <= mul_next;
    end

    // ------------------------------------------------------------------
    // Pack stage: divide by 255, place the fields and OR them together; an outside pixel gives a zero word.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] word_reg, word_next;
    logic              outside_reg;

    always_comb
    begin
        word_next = place(chan_sel(mul_reg.prod_red, mul_reg.raw_red, red_bits_reg),
                          red_position_reg)
                  | place(chan_sel(mul_reg.prod_green, mul_reg.raw_green, green_bits_reg),
                          green_position_reg)
                  | place(chan_sel(mul_reg.prod_blue, mul_reg.raw_blue, blue_bits_reg),
                          blue_position_reg);
        if (mul_reg.outside)
            word_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OUT_IDX])
        begin
            word_reg    <= word_next;
            outside_reg <= mul_reg.outside;
        end
    end

    assign pixel.valid         = vld_reg[OUT_IDX];
    assign pixel.pixel_word    = word_reg;
    assign pixel.outside_frame = outside_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.outside_frame |-> pixel.pixel_word == '0)
        else $error("outside pixel carries a nonzero word");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !coord.ready |-> (&vld_reg) && !pixel.ready)
        else $error("input blocked while the pipeline has room");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        coord.valid && coord.ready |=> vld_reg[0])
        else $error("accepted coordinate did not enter the prep stage");

    a_red_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QUO_STEPS] && !div_reg[QUO_STEPS].outside
            |-> DIV_CMP_W'(div_reg[QUO_STEPS].rem_red) < DIV_CMP_W'(w_lim))
        else $error("red ramp remainder not below the divisor");

    a_green_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QUO_STEPS] && !div_reg[QUO_STEPS].outside
            |-> DIV_CMP_W'(div_reg[QUO_STEPS].rem_green) < DIV_CMP_W'(h_lim))
        else $error("green ramp remainder not below the divisor");

endmodule

// ===== tb/gradient_pattern_pixel_packer_tb.sv =====
// ----------------------------------------------------------------------------
// gradient_pattern_pixel_packer_tb
// Drives pixel coordinates through the pattern packer under a series of frame
// and channel settings, predicts every packed pixel word and checks them in
// order, with random gaps on the coordinate side and random back-pressure on
// the pixel side.
// ----------------------------------------------------------------------------
module gradient_pattern_pixel_packer_tb;
    import gpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_MAX  = 4096;
    localparam int unsigned COORD_TOP  = 4095;
    localparam int          DRAIN_WAIT = 16;
    localparam int          RANDOM_PER_PHASE = 200;
    localparam int          PHASES     = 9;

    typedef struct {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [WORD_W-1:0] word;
        logic              outside;
    } pixel_expect_t;

    typedef struct {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [BITS_W-1:0] red_bits;
        logic [BITS_W-1:0] green_bits;
        logic [BITS_W-1:0] blue_bits;
        logic [POS_W-1:0]  red_pos;
        logic [POS_W-1:0]  green_pos;
        logic [POS_W-1:0]  blue_pos;
    } pattern_setting_t;

    class pixel_checker;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [BITS_W-1:0] red_bits;
        logic [BITS_W-1:0] green_bits;
        logic [BITS_W-1:0] blue_bits;
        logic [POS_W-1:0]  red_pos;
        logic [POS_W-1:0]  green_pos;
        logic [POS_W-1:0]  blue_pos;
        pixel_expect_t     expected_pixels[$];
        int unsigned       failures;

        function new();
            frame_width  = RST_FRAME_WIDTH;
            frame_height = RST_FRAME_HEIGHT;
            red_bits     = RST_RED_BITS;
            red_pos      = RST_RED_POSITION;
            green_bits   = RST_GREEN_BITS;
            green_pos    = RST_GREEN_POSITION;
            blue_bits    = RST_BLUE_BITS;
            blue_pos     = RST_BLUE_POSITION;
            failures     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            unique case (idx)
                REG_FRAME_WIDTH:    frame_width  = data[DIM_W-1:0];
                REG_FRAME_HEIGHT:   frame_height = data[DIM_W-1:0];
                REG_RED_BITS:       red_bits     = data[BITS_W-1:0];
                REG_RED_POSITION:   red_pos      = data[POS_W-1:0];
                REG_GREEN_BITS:     green_bits   = data[BITS_W-1:0];
                REG_GREEN_POSITION: green_pos    = data[POS_W-1:0];
                REG_BLUE_BITS:      blue_bits    = data[BITS_W-1:0];
                REG_BLUE_POSITION:  blue_pos     = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // Register values beyond the largest frame are held at that size.
        function int unsigned frame_limit(logic [DIM_W-1:0] d);
            return (d > FRAME_MAX) ? FRAME_MAX : int'(d);
        endfunction

        function int unsigned frame_cols();
            return frame_limit(frame_width);
        endfunction

        function int unsigned frame_rows();
            return frame_limit(frame_height);
        endfunction

        function int unsigned fit_field(int unsigned v, logic [BITS_W-1:0] n);
            if (n == 0)
                return 0;
            if (n >= 8)
                return v & 8'hFF;
            return ((v & 8'hFF) * ((1 << n) - 1) + 127) / 255;
        endfunction

        function pixel_expect_t predict_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            pixel_expect_t e;
            int unsigned   w;
            int unsigned   h;
            int unsigned   x;
            int unsigned   y;
            logic [63:0]   acc;
            w = frame_cols();
            h = frame_rows();
            x = 32'(col);
            y = 32'(row);
            e.col     = col;
            e.row     = row;
            e.word    = '0;
            e.outside = 1'b1;
            // A zero width or height lands here too, so no divide by zero.
            if (x >= w || y >= h)
                return e;
            acc = (64'(fit_field((x * 255) / w, red_bits)) << red_pos)
                | (64'(fit_field((y * 255) / h, green_bits)) << green_pos)
                | (64'(fit_field((x ^ y) & 8'hFF, blue_bits)) << blue_pos);
            e.word    = acc[WORD_W-1:0];
            e.outside = 1'b0;
            return e;
        endfunction

        function void note_coord(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            expected_pixels.push_back(predict_pixel(col, row));
        endfunction

        function void check_pixel(logic [WORD_W-1:0] word, logic outside);
            pixel_expect_t e;
            if (expected_pixels.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel word %h outside %b", word, outside);
                return;
            end
            e = expected_pixels.pop_front();
            if (word !== e.word || outside !== e.outside)
            begin
                failures++;
                if (failures <= 10)
                    $display("pixel (%0d,%0d): expected word %h outside %b, got %h outside %b",
                             e.col, e.row, e.word, e.outside, word, outside);
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit   steady;

    gpp_coord_if coord_ch();
    gpp_pixel_if pixel_ch();

    pixel_checker chk = new();

    gradient_pattern_pixel_packer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .coord     (coord_ch),
        .pixel     (pixel_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Pixel side: take a word when offered, stall at random.
    always @(posedge clk)
    begin
        if (pixel_ch.valid && pixel_ch.ready)
            chk.check_pixel(pixel_ch.pixel_word, pixel_ch.outside_frame);
        pixel_ch.ready <= steady || ($urandom_range(99) >= 17);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        chk.set_register(idx, data);
    endtask

    // Narrow registers get random upper bits, which the block must drop.
    task automatic load_setting(pattern_setting_t s);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_FRAME_WIDTH, s.width);
        write_reg(REG_FRAME_HEIGHT, s.height);
        write_reg(REG_RED_BITS, {junk[CFG_DATA_W-1:BITS_W], s.red_bits});
        write_reg(REG_RED_POSITION, {junk[CFG_DATA_W-1:POS_W], s.red_pos});
        write_reg(REG_GREEN_BITS, {junk[CFG_DATA_W-1:BITS_W], s.green_bits});
        write_reg(REG_GREEN_POSITION, {junk[CFG_DATA_W-1:POS_W], s.green_pos});
        write_reg(REG_BLUE_BITS, {junk[CFG_DATA_W-1:BITS_W], s.blue_bits});
        write_reg(REG_BLUE_POSITION, {junk[CFG_DATA_W-1:POS_W], s.blue_pos});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_coord(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        while (!steady && $urandom_range(99) < 17)
        begin
            coord_ch.valid <= 1'b0;
            @(posedge clk);
        end
        coord_ch.valid        <= 1'b1;
        coord_ch.pixel_column <= col;
        coord_ch.pixel_row    <= row;
        do
            @(posedge clk);
        while (!coord_ch.ready);
        chk.note_coord(col, row);
    endtask

    // Picks the last coordinate inside the frame or the first one outside it.
    function automatic logic [11:0] near_limit(int unsigned d);
        int unsigned v;
        v = (d == 0) ? 0 : d - 1 + $urandom_range(1);
        return (v > COORD_TOP) ? 12'(COORD_TOP) : 12'(v);
    endfunction

    task automatic send_corners();
        int unsigned w;
        int unsigned h;
        logic [11:0] last_col;
        logic [11:0] last_row;
        w = chk.frame_cols();
        h = chk.frame_rows();
        last_col = (w == 0) ? 12'd0 : 12'(w - 1);
        last_row = (h == 0) ? 12'd0 : 12'(h - 1);
        send_coord(12'd0, 12'd0);
        send_coord(last_col, last_row);
        send_coord(last_col, 12'd0);
        send_coord(12'd0, last_row);
        send_coord((w > COORD_TOP) ? 12'(COORD_TOP) : 12'(w), 12'd0);
        send_coord(12'd0, (h > COORD_TOP) ? 12'(COORD_TOP) : 12'(h));
        send_coord(12'(COORD_TOP), 12'(COORD_TOP));
    endtask

    task automatic send_random();
        int unsigned w;
        int unsigned h;
        int unsigned roll;
        logic [11:0] col;
        logic [11:0] row;
        w = chk.frame_cols();
        h = chk.frame_rows();
        roll = $urandom_range(99);
        if (roll < 75 && w != 0 && h != 0)
        begin
            col = 12'($urandom_range(w - 1));
            row = 12'($urandom_range(h - 1));
        end
        else if (roll < 88)
        begin
            col = near_limit(w);
            row = near_limit(h);
        end
        else
        begin
            col = 12'($urandom);
            row = 12'($urandom);
        end
        send_coord(col, row);
    endtask

    // Lowers valid and waits for the pipeline to empty.
    task automatic finish_burst();
        coord_ch.valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [DIM_W-1:0] random_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return DIM_W'($urandom_range(16, 1));
        if (roll < 70)
            return DIM_W'($urandom_range(FRAME_MAX, 1));
        if (roll < 85)
            return DIM_W'(FRAME_MAX);
        if (roll < 95)
            return DIM_W'($urandom_range(8191, FRAME_MAX + 1));
        return '0;
    endfunction

    function automatic pattern_setting_t random_setting();
        pattern_setting_t s;
        s.width      = random_dim();
        s.height     = random_dim();
        s.red_bits   = BITS_W'($urandom);
        s.green_bits = BITS_W'($urandom);
        s.blue_bits  = BITS_W'($urandom);
        s.red_pos    = POS_W'($urandom);
        s.green_pos  = POS_W'($urandom);
        s.blue_pos   = POS_W'($urandom);
        return s;
    endfunction

    initial
    begin
        pattern_setting_t s;
        int               phase;
        int               n;
        rst_n                 = 1'b0;
        steady                = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        coord_ch.valid        = 1'b0;
        coord_ch.pixel_column = '0;
        coord_ch.pixel_row    = '0;
        pixel_ch.ready        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on settings: corners, alternating bit patterns, and a blue
        // xor that spills above eight bits.
        send_corners();
        send_coord(12'h555, 12'h0AA);
        send_coord(12'h155, 12'h0AA);
        send_coord(12'hAAA, 12'h155);
        send_coord(12'd255, 12'd256);
        send_coord(12'd320, 12'd240);
        finish_burst();

        for (phase = 0; phase < PHASES; phase++)
        begin
            s = random_setting();
            case (phase)
                0: s = '{13'd1, 13'd1, 4'd0, 4'd15, 4'd1, 5'd31, 5'd0, 5'd30};
                1: s = '{13'd4096, 13'd4096, 4'd8, 4'd7, 4'd1, 5'd0, 5'd25, 5'd31};
                2: s = '{13'd8191, 13'd4097, 4'd1, 4'd2, 4'd3, 5'd29, 5'd30, 5'd31};
                3: s.width = '0;
                4: s.height = '0;
                default: ;
            endcase
            load_setting(s);
            steady = (phase == 6);
            send_corners();
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                send_random();
            finish_burst();
        end

        if (chk.failures == 0 && chk.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
